[rtl/core/ast_pkg.sv]
// address snapshot table package: sizes, operation and status codes,
// transaction and record types shared by the table core and its record store
// no dependencies
`default_nettype none

package ast_pkg;

  // table capacity and short address range
  localparam int unsigned MAX_RECORDS   = 128;
  localparam int unsigned ADDRESS_COUNT = 64;

  // record index and record count widths
  localparam int unsigned IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

  // address spaces that the table accepts
  localparam logic [1:0] SPACE_GEAR  = 2'd0;
  localparam logic [1:0] SPACE_INPUT = 2'd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_FIND  = 2'd2,
    OP_MASK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // input transaction
  typedef struct packed {
    op_e         op;
    logic [1:0]  space;
    logic [7:0]  unit_addr;
    logic [15:0] group_bits;
    logic        has_ident;
    logic        has_product_code;
    logic        has_group_bits;
    logic [63:0] ident;
    logic [47:0] product_code;
  } ast_in_t;

  // result transaction
  typedef struct packed {
    status_e     status;
    logic        found;
    logic        duplicate;
    logic [6:0]  found_index;
    logic [5:0]  found_address;
    logic [15:0] found_groups;
    logic [2:0]  found_flags;
    logic [47:0] found_product_code;
    logic [63:0] used_mask;
    logic [7:0]  record_count;
  } ast_out_t;

  // one stored record, space is 0 or 1 once validated
  typedef struct packed {
    logic        space;
    logic [5:0]  addr;
    logic [2:0]  flags;
    logic [15:0] groups;
    logic [63:0] ident;
    logic [47:0] product;
  } ast_rec_t;

  function automatic logic space_ok(input logic [1:0] space);
    return (space == SPACE_GEAR) || (space == SPACE_INPUT);
  endfunction

endpackage

`default_nettype wire

[rtl/core/ast_rec_store.sv]
// record store of the address snapshot table: one write port, one read port
// with registered read data; depends on ast_pkg
`default_nettype none

module ast_rec_store
  import ast_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire ast_rec_t         wr_rec_i,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output ast_rec_t              rd_rec_o
);

  ast_rec_t mem_q [MAX_RECORDS];
  ast_rec_t rd_rec_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_rec_i;
    end
  end

  // read port, data registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_rec_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_rec_o = rd_rec_q;

endmodule

`default_nettype wire

[rtl/core/address_snapshot_table_unit.sv]
// address snapshot table top level: command port, record scan sequencer,
// result register; depends on ast_pkg and ast_rec_store
//
// A transaction is taken when start is high and busy is low; its result is
// shown on result_o for exactly one cycle with done_o high, and cannot be
// held off by the receiver. Clear, add, and any find or mask that needs no
// scan (bad space, zero key, empty table) give their result in the cycle
// after the transaction is taken, and busy stays low. Find and mask walk
// every held record through the single read port of the record store, one
// record a cycle, and give their result once the last record is folded in;
// busy is high meanwhile.
// The record store needs no clearing after reset: only positions below the
// record count are ever read.
`default_nettype none

module address_snapshot_table_unit
  import ast_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire ast_in_t in_i,
  output logic      done_o,
  output ast_out_t  result_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             dv_q;
  logic [IDX_W-1:0] di_q;
  op_e              op_q, op_d;
  logic             space_q, space_d;
  logic [63:0]      key_q, key_d;
  logic             hit_q, hit_d;
  logic             dup_q, dup_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  ast_rec_t         hit_rec_q, hit_rec_d;
  logic [63:0]      mask_q, mask_d;
  logic             done_q, done_d;
  ast_out_t         result_q, result_d;

  logic             rd_en;
  logic             wr_en;
  ast_rec_t         wr_rec;
  ast_rec_t         rd_rec;
  logic             last_idx;

  ast_rec_store u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_idx_i (count_q[IDX_W-1:0]),
    .wr_rec_i (wr_rec),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx_q),
    .rd_rec_o (rd_rec)
  );

  assign last_idx = (CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q;

  // record to append on add
  always_comb begin
    wr_rec.space   = in_i.space[0];
    wr_rec.addr    = in_i.unit_addr[5:0];
    wr_rec.flags   = {in_i.has_group_bits, in_i.has_product_code, in_i.has_ident};
    wr_rec.groups  = in_i.group_bits;
    wr_rec.ident   = in_i.ident;
    wr_rec.product = in_i.product_code;
  end

  // command decode, scan sequencing and result assembly
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    op_d      = op_q;
    space_d   = space_q;
    key_d     = key_q;
    hit_d     = hit_q;
    dup_d     = dup_q;
    hit_idx_d = hit_idx_q;
    hit_rec_d = hit_rec_q;
    mask_d    = mask_q;
    done_d    = 1'b0;
    result_d  = result_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          result_d = '0;
          case (in_i.op)
            OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            OP_ADD: begin
              done_d = 1'b1;
              if (!space_ok(in_i.space) ||
                  (in_i.unit_addr >= 8'(ADDRESS_COUNT))) begin
                result_d.status = ST_INVALID;
              end else if (count_q >= CNT_W'(MAX_RECORDS)) begin
                result_d.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_FIND, OP_MASK: begin
              if (!space_ok(in_i.space)) begin
                result_d.status = ST_INVALID;
                done_d          = 1'b1;
              end else if (((in_i.op == OP_FIND) && (in_i.ident == 64'd0)) ||
                           (count_q == '0)) begin
                done_d = 1'b1;
              end else begin
                state_d  = S_SCAN;
                rd_idx_d = '0;
                op_d     = in_i.op;
                space_d  = in_i.space[0];
                key_d    = in_i.ident;
                hit_d    = 1'b0;
                dup_d    = 1'b0;
                mask_d   = '0;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en    = 1'b1;
        rd_idx_d = rd_idx_q + IDX_W'(1);
        if (last_idx) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // fold in the record read in the previous cycle
    if (dv_q) begin
      if ((op_q == OP_FIND) && (rd_rec.space == space_q) && rd_rec.flags[0] &&
          (rd_rec.ident == key_q)) begin
        if (hit_q) begin
          dup_d = 1'b1;
        end else begin
          hit_d     = 1'b1;
          hit_idx_d = di_q;
          hit_rec_d = rd_rec;
        end
      end
      if ((op_q == OP_MASK) && (rd_rec.space == space_q) &&
          ({1'b0, rd_rec.addr} < 7'(ADDRESS_COUNT))) begin
        mask_d[rd_rec.addr] = 1'b1;
      end
    end

    // scan result once the last record is folded in
    if (state_q == S_LAST) begin
      done_d   = 1'b1;
      result_d = '0;
      if (op_q == OP_MASK) begin
        result_d.used_mask = mask_d;
      end else if (hit_d) begin
        result_d.found              = 1'b1;
        result_d.duplicate          = dup_d;
        result_d.found_index        = 7'(hit_idx_d);
        result_d.found_address      = hit_rec_d.addr;
        result_d.found_groups       = hit_rec_d.groups;
        result_d.found_flags        = hit_rec_d.flags;
        result_d.found_product_code = hit_rec_d.product;
      end
    end

    if (done_d) begin
      result_d.record_count = 8'(count_d);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      dv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      dv_q    <= rd_en;
      done_q  <= done_d;
    end
  end

  // scan and result payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    di_q      <= rd_idx_q;
    op_q      <= op_d;
    space_q   <= space_d;
    key_q     <= key_d;
    hit_q     <= hit_d;
    dup_q     <= dup_d;
    hit_idx_q <= hit_idx_d;
    hit_rec_q <= hit_rec_d;
    mask_q    <= mask_d;
    result_q  <= result_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef ASSERT_OFF
  // record count stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECORDS))
    else $error("record count above capacity");

  // appends only below capacity
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (count_q < CNT_W'(MAX_RECORDS)))
    else $error("record written into a full table");

  // scan reads only held records
  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (CNT_W'(rd_idx_q) < count_q))
    else $error("scan read beyond record count");

  // a result always leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result shown while scan still running");

  // reported count matches the held count
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (result_q.record_count == 8'(count_q)))
    else $error("result record count differs from table count");
`endif

endmodule

`default_nettype wire

[tb/tb_address_snapshot_table_unit.sv]
// self-checking testbench for address_snapshot_table_unit: directed table then random
// clear/add/find/mask episodes, each result checked against a local table model
// depends on ast_pkg and the address_snapshot_table_unit rtl
module tb_address_snapshot_table_unit
  import ast_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1900;

  // one stored entry of the local table copy
  typedef struct packed {
    logic [1:0]  space;
    logic [5:0]  addr;
    logic [2:0]  flags;
    logic [15:0] groups;
    logic [63:0] ident;
    logic [47:0] product;
  } entry_t;

  // one row of the directed table, want is used only when typed is set
  typedef struct {
    ast_in_t  cmd;
    bit       typed;
    ast_out_t want;
  } step_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  ast_in_t  in_i = '0;
  logic     busy;
  logic     done_o;
  ast_out_t result_o;

  entry_t      tbl[MAX_RECORDS];
  int unsigned rec_count = 0;
  ast_out_t    expected_results[$];
  step_t       steps[$];
  logic [63:0] ident_pool[$];
  int          n_errors = 0;
  int          n_results = 0;
  int          n_random = 0;
  int          idle_pct = 0;

  address_snapshot_table_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .in_i     (in_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #1 clk_i = ~clk_i;

  // hard limit, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at result %0d: %s", n_results, msg);
    n_errors++;
  endtask

  // table model: applies one command and returns the result it should give
  function automatic ast_out_t table_predict(input ast_in_t c);
    ast_out_t r;
    bit       space_valid;
    bit       hit;
    r = '0;
    hit = 1'b0;
    space_valid = (c.space == SPACE_GEAR) || (c.space == SPACE_INPUT);
    case (c.op)
      OP_CLEAR: begin
        rec_count = 0;
      end
      OP_ADD: begin
        if (!space_valid || c.unit_addr >= ADDRESS_COUNT) begin
          r.status = ST_INVALID;
        end else if (rec_count >= MAX_RECORDS) begin
          r.status = ST_FULL;
        end else begin
          tbl[rec_count] = '{space: c.space, addr: c.unit_addr[5:0],
                             flags: {c.has_group_bits, c.has_product_code, c.has_ident},
                             groups: c.group_bits, ident: c.ident,
                             product: c.product_code};
          rec_count++;
        end
      end
      OP_FIND: begin
        if (!space_valid) begin
          r.status = ST_INVALID;
        end else if (c.ident != '0) begin
          // first hit in table order wins, a second hit only sets duplicate
          for (int i = 0; i < rec_count; i++) begin
            if (tbl[i].space == c.space && tbl[i].flags[0] && tbl[i].ident == c.ident) begin
              if (hit) begin
                r.duplicate = 1'b1;
                break;
              end
              hit = 1'b1;
              r.found = 1'b1;
              r.found_index = i[6:0];
              r.found_address = tbl[i].addr;
              r.found_groups = tbl[i].groups;
              r.found_flags = tbl[i].flags;
              r.found_product_code = tbl[i].product;
            end
          end
        end
      end
      default: begin
        if (!space_valid) begin
          r.status = ST_INVALID;
        end else begin
          for (int i = 0; i < rec_count; i++) begin
            if (tbl[i].space == c.space) r.used_mask[tbl[i].addr] = 1'b1;
          end
        end
      end
    endcase
    r.record_count = rec_count[7:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // every field random, op and space over their whole range
  function automatic ast_in_t rand_cmd();
    ast_in_t c;
    c.op = op_e'(2'($urandom_range(3)));
    c.space = 2'($urandom_range(3));
    c.unit_addr = 8'($urandom_range(255));
    c.group_bits = 16'($urandom_range(16'hffff));
    c.has_ident = 1'($urandom_range(1));
    c.has_product_code = 1'($urandom_range(1));
    c.has_group_bits = 1'($urandom_range(1));
    c.ident = rand64();
    c.product_code = {16'($urandom), $urandom};
    return c;
  endfunction

  function automatic ast_in_t make_cmd(input op_e op, input logic [1:0] space,
                                       input logic [7:0] addr, input logic [15:0] groups,
                                       input logic [2:0] flags, input logic [63:0] ident,
                                       input logic [47:0] pc);
    ast_in_t c;
    c.op = op;
    c.space = space;
    c.unit_addr = addr;
    c.group_bits = groups;
    c.has_ident = flags[0];
    c.has_product_code = flags[1];
    c.has_group_bits = flags[2];
    c.ident = ident;
    c.product_code = pc;
    return c;
  endfunction

  function automatic ast_out_t plain_result(input status_e st, input logic [7:0] cnt);
    ast_out_t r;
    r = '0;
    r.status = st;
    r.record_count = cnt;
    return r;
  endfunction

  function automatic void add_row(input ast_in_t c, input bit typed, input ast_out_t want);
    step_t s;
    s.cmd = c;
    s.typed = typed;
    s.want = want;
    steps.push_back(s);
  endfunction

  // one transaction: hold start until busy is seen low at an edge
  task automatic send_cmd(input ast_in_t c, input bit typed, input ast_out_t want);
    ast_out_t p;
    start <= 1'b1;
    in_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    p = table_predict(c);
    expected_results.push_back(typed ? want : p);
    // sender gap, random junk on the payload while start is low
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_i <= rand_cmd();
      @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] pick_ident(input int pool_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < pool_pct) return ident_pool[$urandom_range(ident_pool.size() - 1)];
    if (roll < pool_pct + 10) return '0;
    return rand64();
  endfunction

  // clear, then fill toward a target with finds, masks and noise mixed in
  task automatic run_episode();
    ast_in_t c;
    int      target;
    int      n_added;
    int      roll;
    ident_pool.delete();
    repeat (4) ident_pool.push_back(rand64());
    c = rand_cmd();
    c.op = OP_CLEAR;
    send_cmd(c, 1'b0, '0);
    n_random++;
    n_added = 0;
    if ($urandom_range(7) == 0) target = $urandom_range(MAX_RECORDS - 8, MAX_RECORDS + 6);
    else target = $urandom_range(1, 24);
    while (n_added < target && n_random < RANDOM_ITEMS) begin
      c = rand_cmd();
      roll = $urandom_range(99);
      if (roll < 55) begin
        c.op = OP_ADD;
        c.space = 2'($urandom_range(1));
        c.unit_addr = 8'($urandom_range(ADDRESS_COUNT - 1));
        c.ident = pick_ident(50);
        n_added++;
      end else if (roll < 75) begin
        c.op = OP_FIND;
        c.space = 2'($urandom_range(1));
        c.ident = pick_ident(70);
      end else if (roll < 85) begin
        c.op = OP_MASK;
        c.space = 2'($urandom_range(1));
      end else if (c.op == OP_CLEAR) begin
        // noise, but keep the table growing
        c.op = OP_MASK;
      end
      send_cmd(c, 1'b0, '0);
      n_random++;
    end
  endtask

  // result checker, one transaction per strobe
  always @(posedge clk_i) begin
    ast_out_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (result_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", result_o.status, want.status));
        if (result_o.found !== want.found)
          report_mismatch($sformatf("found got %b want %b", result_o.found, want.found));
        if (result_o.duplicate !== want.duplicate)
          report_mismatch($sformatf("duplicate got %b want %b",
                                    result_o.duplicate, want.duplicate));
        if (result_o.found_index !== want.found_index)
          report_mismatch($sformatf("found_index got %0d want %0d",
                                    result_o.found_index, want.found_index));
        if (result_o.found_address !== want.found_address)
          report_mismatch($sformatf("found_address got %0d want %0d",
                                    result_o.found_address, want.found_address));
        if (result_o.found_groups !== want.found_groups)
          report_mismatch($sformatf("found_groups got %h want %h",
                                    result_o.found_groups, want.found_groups));
        if (result_o.found_flags !== want.found_flags)
          report_mismatch($sformatf("found_flags got %b want %b",
                                    result_o.found_flags, want.found_flags));
        if (result_o.found_product_code !== want.found_product_code)
          report_mismatch($sformatf("found_product_code got %h want %h",
                                    result_o.found_product_code, want.found_product_code));
        if (result_o.used_mask !== want.used_mask)
          report_mismatch($sformatf("used_mask got %h want %h",
                                    result_o.used_mask, want.used_mask));
        if (result_o.record_count !== want.record_count)
          report_mismatch($sformatf("record_count got %0d want %0d",
                                    result_o.record_count, want.record_count));
      end
      n_results++;
    end
  end

  // stimulus
  initial begin
    logic [63:0] ones;
    int          phase;
    ones = '1;

    // empty table, bad arguments, then a small table with shared identifications
    add_row(make_cmd(OP_MASK, SPACE_GEAR, 8'd0, 16'h0, 3'b000, 64'h0, 48'h0),
            1'b1, plain_result(ST_OK, 8'd0));
    add_row(make_cmd(OP_FIND, SPACE_INPUT, 8'd0, 16'h0, 3'b000, ones, 48'h0),
            1'b1, plain_result(ST_OK, 8'd0));
    add_row(make_cmd(OP_ADD, 2'd2, 8'd1, 16'h1234, 3'b111, 64'h5, 48'h1),
            1'b1, plain_result(ST_INVALID, 8'd0));
    add_row(make_cmd(OP_ADD, 2'd3, 8'd0, 16'h0, 3'b001, 64'h5, 48'h0),
            1'b1, plain_result(ST_INVALID, 8'd0));
    add_row(make_cmd(OP_ADD, SPACE_GEAR, 8'd64, 16'h0, 3'b001, 64'h5, 48'h0),
            1'b1, plain_result(ST_INVALID, 8'd0));
    add_row(make_cmd(OP_ADD, SPACE_INPUT, 8'd255, 16'hffff, 3'b111, ones, '1),
            1'b1, plain_result(ST_INVALID, 8'd0));
    add_row(make_cmd(OP_ADD, SPACE_GEAR, 8'd0, 16'hffff, 3'b111, ones, '1),
            1'b1, plain_result(ST_OK, 8'd1));
    add_row(make_cmd(OP_ADD, SPACE_INPUT, 8'd63, 16'h0, 3'b000, 64'h0, 48'h0),
            1'b1, plain_result(ST_OK, 8'd2));
    add_row(make_cmd(OP_ADD, SPACE_GEAR, 8'd63, 16'h00f0, 3'b001, 64'h5, 48'habc), 1'b0, '0);
    add_row(make_cmd(OP_ADD, SPACE_INPUT, 8'd5, 16'h0f00, 3'b011, 64'h5, 48'hdef), 1'b0, '0);
    add_row(make_cmd(OP_ADD, SPACE_GEAR, 8'd7, 16'h8001, 3'b101, 64'h5, 48'h123), 1'b0, '0);
    add_row(make_cmd(OP_ADD, SPACE_GEAR, 8'd9, 16'h5555, 3'b110, 64'h6, 48'h456), 1'b0, '0);
    // two hits in the gear space, one in the input space, flag off, zero key
    add_row(make_cmd(OP_FIND, SPACE_GEAR, 8'd0, 16'h0, 3'b000, 64'h5, 48'h0), 1'b0, '0);
    add_row(make_cmd(OP_FIND, SPACE_INPUT, 8'd0, 16'h0, 3'b000, 64'h5, 48'h0), 1'b0, '0);
    add_row(make_cmd(OP_FIND, SPACE_GEAR, 8'd0, 16'h0, 3'b000, 64'h6, 48'h0), 1'b0, '0);
    add_row(make_cmd(OP_FIND, SPACE_GEAR, 8'd0, 16'h0, 3'b000, 64'h0, 48'h0), 1'b0, '0);
    add_row(make_cmd(OP_FIND, 2'd2, 8'd0, 16'h0, 3'b000, 64'h5, 48'h0),
            1'b1, plain_result(ST_INVALID, 8'd6));
    add_row(make_cmd(OP_MASK, 2'd3, 8'd0, 16'h0, 3'b000, 64'h0, 48'h0),
            1'b1, plain_result(ST_INVALID, 8'd6));
    add_row(make_cmd(OP_MASK, SPACE_GEAR, 8'd0, 16'h0, 3'b000, 64'h0, 48'h0), 1'b0, '0);
    add_row(make_cmd(OP_MASK, SPACE_INPUT, 8'd0, 16'h0, 3'b000, 64'h0, 48'h0), 1'b0, '0);
    add_row(make_cmd(OP_FIND, SPACE_GEAR, 8'd0, 16'h0, 3'b000, ones, 48'h0), 1'b0, '0);
    add_row(make_cmd(OP_CLEAR, 2'd3, 8'd255, 16'hffff, 3'b111, ones, '1),
            1'b1, plain_result(ST_OK, 8'd0));
    add_row(make_cmd(OP_FIND, SPACE_GEAR, 8'd0, 16'h0, 3'b000, 64'h5, 48'h0),
            1'b1, plain_result(ST_OK, 8'd0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) send_cmd(steps[i].cmd, steps[i].typed, steps[i].want);

    // random episodes, sender idling changes every couple hundred transactions
    while (n_random < RANDOM_ITEMS) begin
      phase = (n_random / 200) % 3;
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 88 : 22;
      run_episode();
    end
    start <= 1'b0;

    // drain, then watch for stray strobes over one full scan
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (MAX_RECORDS + 8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
